FILE: hdl/pij_pkg.sv
// ----------------------------------------------------------------------------
// pij_pkg
// Shared widths, status codes, pipeline types and the row arithmetic helpers
// of the point interaction Jacobian block.
// ----------------------------------------------------------------------------
package pij_pkg;

  localparam int X_W = 18;
  localparam int Z_W = 24;
  localparam int J_W = 24;
  localparam int IN_TDATA_W = 208;
  localparam int OUT_VAL_W = 32;
  localparam int OUT_TDATA_W = 2 * OUT_VAL_W;
  localparam int OUT_TUSER_W = 4;

  localparam int MULT_XJ_W = X_W + J_W;
  localparam int MULT_XX_W = 2 * X_W;
  localparam int A_W = 42;
  localparam int N_W = 44;
  localparam int QB = 34;
  localparam int D_W = Z_W;
  localparam int QA_W = 30;
  localparam int Q48_W = 64;
  localparam int SUM_W = QB + 3;

  localparam int DIV_STEPS = 2;
  localparam int DIV_STAGES = QB / DIV_STEPS;
  localparam int FRONT_STAGES = 3;
  localparam int PIPE_LAT = FRONT_STAGES + DIV_STAGES;

  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int CNT_W = FIFO_AW + 1;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_NEG = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;
  localparam logic [1:0] ROW_SEL_RESET = 2'b11;

  localparam logic [MULT_XX_W-1:0] ONE_Q32 = MULT_XX_W'(64'h1_0000_0000);
  localparam logic signed [Q48_W-1:0] ROUND_Q32 = 64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic signed [X_W-1:0] point_x;
    logic signed [X_W-1:0] point_y;
    logic signed [Z_W-1:0] depth;
    logic signed [J_W-1:0] jac_vx;
    logic signed [J_W-1:0] jac_vy;
    logic signed [J_W-1:0] jac_vz;
    logic signed [J_W-1:0] jac_wx;
    logic signed [J_W-1:0] jac_wy;
    logic signed [J_W-1:0] jac_wz;
    logic last_column;
  } in_item_t;

  typedef struct packed {
    logic [D_W-1:0] rem;
    logic [QB-1:0] nq;
  } div_row_t;

  typedef struct packed {
    logic neg;
    logic clamp;
    logic signed [QA_W-1:0] qang;
  } row_side_t;

  typedef struct packed {
    div_row_t dx;
    div_row_t dy;
    logic [D_W-1:0] dvsr;
    row_side_t sx;
    row_side_t sy;
    logic [1:0] status;
    logic last;
  } div_item_t;

  typedef struct packed {
    logic [OUT_VAL_W-1:0] first_value;
    logic [OUT_VAL_W-1:0] second_value;
    logic [1:0] row_count;
    logic [1:0] status;
    logic last_out;
  } out_item_t;

  function automatic div_row_t div_step(div_row_t r, logic [D_W-1:0] d);
    logic [D_W:0] t;
    logic [D_W:0] diff;
    div_row_t o;
    t = {r.rem, r.nq[QB-1]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      o.rem = diff[D_W-1:0];
      o.nq = {r.nq[QB-2:0], 1'b1};
    end else begin
      o.rem = t[D_W-1:0];
      o.nq = {r.nq[QB-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [OUT_VAL_W-1:0] row_value(logic [QB-1:0] quo, row_side_t sd);
    logic [QB-1:0] mag;
    logic signed [QB+1:0] p;
    logic signed [SUM_W-1:0] s;
    logic [OUT_VAL_W-1:0] v;
    mag = sd.clamp ? {QB{1'b1}} : quo;
    p = $signed({2'b00, mag});
    if (sd.neg) begin
      p = -p;
    end
    s = SUM_W'(p) + SUM_W'(sd.qang);
    if (s[SUM_W-1:OUT_VAL_W-1] == {(SUM_W-OUT_VAL_W+1){s[SUM_W-1]}}) begin
      v = s[OUT_VAL_W-1:0];
    end else if (s[SUM_W-1]) begin
      v = {1'b1, {(OUT_VAL_W-1){1'b0}}};
    end else begin
      v = {1'b0, {(OUT_VAL_W-1){1'b1}}};
    end
    return v;
  endfunction

endpackage

FILE: hdl/pij_front.sv
// ----------------------------------------------------------------------------
// pij_front
// Three multiply and add stages: products of the image coordinates with the
// Jacobian entries, the angular sums rounded to Q16.16, and the dividend and
// divisor for the translational term.
// ----------------------------------------------------------------------------
module pij_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  pij_pkg::in_item_t     in_item,
  output logic                  out_vld,
  output pij_pkg::div_item_t    out_item
);
  import pij_pkg::*;

  typedef struct packed {
    logic signed [MULT_XJ_W-1:0] xjvz;
    logic signed [MULT_XJ_W-1:0] yjvz;
    logic signed [MULT_XJ_W-1:0] xjwz;
    logic signed [MULT_XJ_W-1:0] yjwz;
    logic signed [MULT_XX_W-1:0] xy;
    logic signed [MULT_XX_W-1:0] xx;
    logic signed [MULT_XX_W-1:0] yy;
    logic signed [J_W-1:0] jvx;
    logic signed [J_W-1:0] jvy;
    logic signed [J_W-1:0] jwx;
    logic signed [J_W-1:0] jwy;
    logic [Z_W-2:0] zmag;
    logic [1:0] status;
    logic last;
  } s1_t;

  typedef struct packed {
    logic signed [A_W-1:0] ax;
    logic signed [A_W-1:0] ay;
    logic signed [MULT_XX_W+J_W-1:0] xy_wx;
    logic signed [MULT_XX_W+J_W-1:0] xy_wy;
    logic signed [MULT_XX_W+J_W:0] xx_wy;
    logic signed [MULT_XX_W+J_W:0] yy_wx;
    logic signed [MULT_XJ_W-1:0] xjwz;
    logic signed [MULT_XJ_W-1:0] yjwz;
    logic [Z_W-2:0] zmag;
    logic [1:0] status;
    logic last;
  } s2_t;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  div_item_t s3_r, s3_nxt;
  logic [FRONT_STAGES-1:0] vld_r;

  function automatic logic [D_W+QB+1:0] make_row(logic signed [A_W-1:0] a,
                                                 logic [Z_W-2:0] zmag);
    logic [A_W-1:0] mag;
    logic [N_W-1:0] n;
    logic [D_W-1:0] d;
    div_row_t r;
    logic clamp;
    mag = a[A_W-1] ? A_W'(-a) : A_W'(a);
    n = N_W'({mag, 1'b0}) + N_W'(zmag);
    d = {zmag, 1'b0};
    r.rem = D_W'(n[N_W-1:QB]);
    r.nq = n[QB-1:0];
    clamp = (D_W'(n[N_W-1:QB]) >= d);
    return {r, a[A_W-1], clamp};
  endfunction

  always_comb begin
    s1_nxt.xjvz = in_item.point_x * in_item.jac_vz;
    s1_nxt.yjvz = in_item.point_y * in_item.jac_vz;
    s1_nxt.xjwz = in_item.point_x * in_item.jac_wz;
    s1_nxt.yjwz = in_item.point_y * in_item.jac_wz;
    s1_nxt.xy = in_item.point_x * in_item.point_y;
    s1_nxt.xx = in_item.point_x * in_item.point_x;
    s1_nxt.yy = in_item.point_y * in_item.point_y;
    s1_nxt.jvx = in_item.jac_vx;
    s1_nxt.jvy = in_item.jac_vy;
    s1_nxt.jwx = in_item.jac_wx;
    s1_nxt.jwy = in_item.jac_wy;
    s1_nxt.zmag = in_item.depth[Z_W-2:0];
    s1_nxt.last = in_item.last_column;
    if (in_item.depth[Z_W-1]) begin
      s1_nxt.status = STAT_NEG;
    end else if (in_item.depth == '0) begin
      s1_nxt.status = STAT_ZERO;
    end else begin
      s1_nxt.status = STAT_OK;
    end
  end

  always_comb begin
    logic [MULT_XX_W-1:0] opx;
    logic [MULT_XX_W-1:0] opy;
    opx = s1_r.xx + ONE_Q32;
    opy = s1_r.yy + ONE_Q32;
    s2_nxt.ax = s1_r.xjvz - $signed({s1_r.jvx, 16'h0000});
    s2_nxt.ay = s1_r.yjvz - $signed({s1_r.jvy, 16'h0000});
    s2_nxt.xy_wx = s1_r.xy * s1_r.jwx;
    s2_nxt.xy_wy = s1_r.xy * s1_r.jwy;
    s2_nxt.xx_wy = $signed({1'b0, opx}) * s1_r.jwy;
    s2_nxt.yy_wx = $signed({1'b0, opy}) * s1_r.jwx;
    s2_nxt.xjwz = s1_r.xjwz;
    s2_nxt.yjwz = s1_r.yjwz;
    s2_nxt.zmag = s1_r.zmag;
    s2_nxt.status = s1_r.status;
    s2_nxt.last = s1_r.last;
  end

  always_comb begin
    logic signed [Q48_W-1:0] qx48;
    logic signed [Q48_W-1:0] qy48;
    qx48 = s2_r.xy_wx - s2_r.xx_wy + $signed({s2_r.yjwz, 16'h0000}) + ROUND_Q32;
    qy48 = s2_r.yy_wx - s2_r.xy_wy - $signed({s2_r.xjwz, 16'h0000}) + ROUND_Q32;
    {s3_nxt.dx, s3_nxt.sx.neg, s3_nxt.sx.clamp} = make_row(s2_r.ax, s2_r.zmag);
    {s3_nxt.dy, s3_nxt.sy.neg, s3_nxt.sy.clamp} = make_row(s2_r.ay, s2_r.zmag);
    s3_nxt.sx.qang = qx48[32+QA_W-1:32];
    s3_nxt.sy.qang = qy48[32+QA_W-1:32];
    s3_nxt.dvsr = {s2_r.zmag, 1'b0};
    s3_nxt.status = s2_r.status;
    s3_nxt.last = s2_r.last;
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_STAGES-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[FRONT_STAGES-1];
  assign out_item = s3_r;

endmodule

FILE: hdl/pij_div.sv
// ----------------------------------------------------------------------------
// pij_div
// Pipelined restoring divider for both rows, two quotient bits per stage,
// sharing the divisor twice the depth.
// ----------------------------------------------------------------------------
module pij_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  pij_pkg::div_item_t    in_item,
  output logic                  out_vld,
  output pij_pkg::div_item_t    out_item
);
  import pij_pkg::*;

  div_item_t st_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_r;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    div_item_t src;
    div_item_t st_nxt;

    if (g == 0) begin : g_first
      assign src = in_item;
    end else begin : g_next
      assign src = st_r[g-1];
    end

    always_comb begin
      st_nxt = src;
      for (int k = 0; k < DIV_STEPS; k++) begin
        st_nxt.dx = div_step(st_nxt.dx, st_nxt.dvsr);
        st_nxt.dy = div_step(st_nxt.dy, st_nxt.dvsr);
      end
    end

    always_ff @(posedge clk) begin
      st_r[g] <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[DIV_STAGES-1];
  assign out_item = st_r[DIV_STAGES-1];

endmodule

FILE: hdl/pij_fifo.sv
// ----------------------------------------------------------------------------
// pij_fifo
// Result queue between the free-running pipeline and the output channel.
// ----------------------------------------------------------------------------
module pij_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  pij_pkg::out_item_t    wr_data,
  input  logic                  rd_en,
  output logic                  rd_vld,
  output pij_pkg::out_item_t    rd_data
);
  import pij_pkg::*;

  out_item_t mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt = cnt_r + CNT_W'(wr_en) - CNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign rd_vld = (cnt_r != '0);
  assign rd_data = mem_r[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cnt_r != CNT_W'(FIFO_DEPTH)))
    else $error("result queue written while full");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow a write");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != CNT_W'(FIFO_DEPTH)) |-> ((wr_ptr_r - rd_ptr_r) == cnt_r[FIFO_AW-1:0]))
    else $error("queue pointers disagree with count");

endmodule

FILE: hdl/point_interaction_jacobian_top.sv
// ----------------------------------------------------------------------------
// point_interaction_jacobian_top
// Point interaction matrix rows times one joint Jacobian column, Q16.16.
// ----------------------------------------------------------------------------
// The block takes one Jacobian column word per clock and returns one result
// word per column, in order. Each word passes 21 registers: three multiply and
// add stages, seventeen divider stages at two quotient bits each, and the
// 32-entry result queue. The pipeline never stalls; in_tready drops only
// while 32 words are in flight or waiting in the queue, or while a cfg_ write
// is taken, so a consumer that is always ready sees full rate. cfg_ready is
// high only while no word is in flight or queued, and a new row_select applies
// to every word accepted after it.
// ----------------------------------------------------------------------------
module point_interaction_jacobian_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // point_x, point_y, depth, jac_vx, jac_vy, jac_vz, jac_wx, jac_wy, jac_wz
  input  logic [pij_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // first_value, second_value
  output logic [pij_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // row_count, status
  output logic [pij_pkg::OUT_TUSER_W-1:0]   out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [1:0]                        cfg_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready
);
  import pij_pkg::*;

  in_item_t in_item;
  logic in_acc;
  logic pop;
  logic front_vld;
  div_item_t front_item;
  logic div_vld;
  div_item_t div_item;
  out_item_t res;
  out_item_t q_item;
  logic [OUT_VAL_W-1:0] vx;
  logic [OUT_VAL_W-1:0] vy;
  logic [1:0] row_sel_r, row_sel_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;

  always_comb begin
    in_item.point_x = in_tdata[17:0];
    in_item.point_y = in_tdata[35:18];
    in_item.depth = in_tdata[59:36];
    in_item.jac_vx = in_tdata[83:60];
    in_item.jac_vy = in_tdata[107:84];
    in_item.jac_vz = in_tdata[131:108];
    in_item.jac_wx = in_tdata[155:132];
    in_item.jac_wy = in_tdata[179:156];
    in_item.jac_wz = in_tdata[203:180];
    in_item.last_column = in_tlast;
  end

  assign in_tready = (occ_r < CNT_W'(FIFO_DEPTH)) && !(cfg_valid && cfg_ready);
  assign in_acc = in_tvalid && in_tready;
  assign pop = out_tvalid && out_tready;
  assign cfg_ready = (occ_r == '0);

  pij_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_acc),
    .in_item  (in_item),
    .out_vld  (front_vld),
    .out_item (front_item)
  );

  pij_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (front_vld),
    .in_item  (front_item),
    .out_vld  (div_vld),
    .out_item (div_item)
  );

  always_comb begin
    vx = row_value(div_item.dx.nq, div_item.sx);
    vy = row_value(div_item.dy.nq, div_item.sy);
    res.row_count = {row_sel_r[0] & row_sel_r[1], row_sel_r[0] ^ row_sel_r[1]};
    res.status = div_item.status;
    res.last_out = div_item.last;
    res.first_value = '0;
    res.second_value = '0;
    if (div_item.status == STAT_OK) begin
      if (row_sel_r[0]) begin
        res.first_value = vx;
        if (row_sel_r[1]) begin
          res.second_value = vy;
        end
      end else if (row_sel_r[1]) begin
        res.first_value = vy;
      end
    end
  end

  pij_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (div_vld),
    .wr_data (res),
    .rd_en   (pop),
    .rd_vld  (out_tvalid),
    .rd_data (q_item)
  );

  assign out_tdata = {q_item.second_value, q_item.first_value};
  assign out_tuser = {q_item.status, q_item.row_count};
  assign out_tlast = q_item.last_out;

  always_comb begin
    row_sel_nxt = (cfg_valid && cfg_ready) ? cfg_data : row_sel_r;
    occ_nxt = occ_r + CNT_W'(in_acc) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_sel_r <= ROW_SEL_RESET;
      occ_r <= '0;
    end else begin
      row_sel_r <= row_sel_nxt;
      occ_r <= occ_nxt;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(FIFO_DEPTH))
    else $error("more words in flight than the queue can hold");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##PIPE_LAT div_vld)
    else $error("accepted word did not reach the result queue in time");

  a_pop_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (occ_r != '0))
    else $error("word delivered with no word in flight");

endmodule
